### hw/rtl/assert_macros.svh
// assertion macros used by the solver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold on every enabled edge
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/tdss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_pkg
// shared types, constants and fixed point helpers of the tridiagonal solver
// ----------------------------------------------------------------------------
package tdss_pkg;
    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int DATA_W    = 32;
    localparam int DIV_W     = DATA_W + FRAC_BITS;     // dividend width
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // datapath commands
    typedef struct packed {
        logic load_row;     // latch input beat
        logic div_start;    // start divider
        logic mul_a;        // first product / difference step
        logic mul_b;        // second product / difference step
        logic write_row;    // write stores
        logic bs_read;      // read row for back substitution
        logic bs_num;       // form numerator
        logic bs_done;      // latch quotient as x
        logic dec_row;      // step back substitution row
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic div_busy;
    } t_stat;

    // saturate a 64-bit value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] mx;
        logic signed [63:0] mn;
        mx = 64'(S_MAX);
        mn = 64'(S_MIN);
        if (v > mx) return S_MAX;
        else if (v < mn) return S_MIN;
        else return v[DATA_W-1:0];
    endfunction

    // product shifted down, floor rounding, saturated
    function automatic logic signed [DATA_W-1:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> FRAC_BITS;
        return sat32(q);
    endfunction
endpackage

### hw/rtl/tridiagonal_system_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_top
// thomas algorithm solver over signed q16.16 rows
// ----------------------------------------------------------------------------
// channel   direction  beat
// row in    input      sub, diag, super, rhs, last_row mark
// x out     output     x value, row index, last, singular, overflowed
//
// rows after the first wait on the 48-step shared divider
// each back substitution result waits on the shared divider and on output stalls
// rows past the depth are taken and dropped
// reset is synchronous active low and clears only control state
// a stalled output holds the sequencer; no rows are taken meanwhile
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_sub_value,
    input  logic signed [31:0] i_diag_value,
    input  logic signed [31:0] i_super_value,
    input  logic signed [31:0] i_rhs_value,
    input  logic               i_last_row,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_x_value,
    output logic [5:0]         o_row_index,
    output logic               o_last_result,
    output logic               o_singular,
    output logic               o_overflowed
);
    import tdss_pkg::*;
`include "assert_macros.svh"

    t_cmd              cmd;
    t_stat             stat;
    logic [ADDR_W-1:0] row;
    logic              first, bs_first, piv_zero, diag_zero;

    tdss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_last_row(i_last_row), .o_valid(o_valid), .i_ready(i_ready),
        .o_cmd(cmd), .i_stat(stat), .o_row(row), .o_first(first),
        .o_bs_first(bs_first), .i_piv_zero(piv_zero), .i_diag_zero(diag_zero),
        .o_row_index(o_row_index), .o_last_result(o_last_result),
        .o_singular(o_singular), .o_overflowed(o_overflowed));

    tdss_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_row(row), .i_first(first), .i_bs_first(bs_first),
        .i_sub_value(i_sub_value), .i_diag_value(i_diag_value),
        .i_super_value(i_super_value), .i_rhs_value(i_rhs_value),
        .i_last_row(i_last_row), .o_piv_zero(piv_zero), .o_diag_zero(diag_zero),
        .o_x_value(o_x_value));

    // no row taken while a result is shown
    `ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(o_valid && o_ready))
    // divider never restarted while busy
    `ASSERT_ALWAYS(a_div_idle, i_clk, i_rst_n, !(cmd.div_start && stat.div_busy))
    // the row-0 result ends the run and reopens input
    `ASSERT_NEXT(a_run_end, i_clk, i_rst_n, o_valid && i_ready && o_last_result, o_ready)
endmodule

### hw/rtl/tdss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tdss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### hw/rtl/tdss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_div
// restoring divider: (a << FRAC_BITS) / b, truncated, saturated, one bit a cycle
// ----------------------------------------------------------------------------
module tdss_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [tdss_pkg::DATA_W-1:0] i_a,
    input  logic signed [tdss_pkg::DATA_W-1:0] i_b,
    output logic                              o_busy,
    output logic signed [tdss_pkg::DATA_W-1:0] o_q
);
    import tdss_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DATA_W:0]      r_rem;
    logic [DATA_W:0]      r_den;
    logic                 r_neg;
    logic                 r_zero;
    logic signed [1:0]    r_zsign;
    logic signed [DATA_W-1:0] r_q;

    logic [DATA_W:0]      n_rem;
    logic [DATA_W:0]      n_diff;
    logic [DIV_W:0]       n_mag;
    logic signed [63:0]   n_sq;
    logic [DATA_W-1:0]    a_mag;

    // dividend magnitude, the most negative value maps to 2^31
    assign a_mag = i_a[DATA_W-1] ? -i_a : i_a;

    // one shift-subtract step
    always_comb begin
        n_rem  = {r_rem[DATA_W-1:0], r_quo[DIV_W-1]};
        n_diff = n_rem - r_den;
        n_mag  = {1'b0, r_quo[DIV_W-2:0], ~n_diff[DATA_W]};
        n_sq   = r_neg ? -64'(n_mag) : 64'(n_mag);
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operand and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= {a_mag, {FRAC_BITS{1'b0}}};
            r_rem   <= '0;
            r_den   <= i_b[DATA_W-1] ? -{i_b[DATA_W-1], i_b} : {1'b0, i_b};
            r_neg   <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_zero  <= (i_b == '0);
            r_zsign <= (i_a == '0) ? 2'sd0 : (i_a[DATA_W-1] ? -2'sd1 : 2'sd1);
        end else if (r_busy) begin
            r_rem <= n_diff[DATA_W] ? n_rem : n_diff;
            r_quo <= n_mag[DIV_W-1:0];
            if (r_cnt == DIV_CNT_W'(1)) begin
                if (r_zero) begin
                    r_q <= (r_zsign == 2'sd1) ? S_MAX : ((r_zsign == -2'sd1) ? S_MIN : '0);
                end else begin
                    r_q <= sat32(n_sq);
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;
endmodule

### hw/rtl/tdss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_datapath
// stores, multiplier, divider and result registers of the solver
// ----------------------------------------------------------------------------
module tdss_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tdss_pkg::t_cmd                     i_cmd,
    output tdss_pkg::t_stat                    o_stat,
    input  logic [tdss_pkg::ADDR_W-1:0]        i_row,
    input  logic                               i_first,
    input  logic                               i_bs_first,
    input  logic signed [tdss_pkg::DATA_W-1:0] i_sub_value,
    input  logic signed [tdss_pkg::DATA_W-1:0] i_diag_value,
    input  logic signed [tdss_pkg::DATA_W-1:0] i_super_value,
    input  logic signed [tdss_pkg::DATA_W-1:0] i_rhs_value,
    input  logic                               i_last_row,
    output logic                               o_piv_zero,
    output logic                               o_diag_zero,
    output logic signed [tdss_pkg::DATA_W-1:0] o_x_value
);
    import tdss_pkg::*;

    logic signed [DATA_W-1:0] r_diag, r_sup, r_rhs, r_m, r_piv, r_rr, r_x, r_num;
    logic signed [DATA_W-1:0] piv_q, up_q, rhs_q, div_q;
    logic signed [DATA_W-1:0] n_piv, n_rr, n_num;
    logic [ADDR_W-1:0]        raddr;
    logic                     div_start;
    logic signed [DATA_W-1:0] div_a, div_b;
    logic signed [63:0]       r_prod;

    // read address: previous row in elimination, current row in back substitution
    assign raddr = i_cmd.bs_read ? i_row : (i_row - 1'b1);

    tdss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_piv (
        .i_clk(i_clk), .i_we(i_cmd.write_row), .i_waddr(i_row),
        .i_wdata(r_piv), .i_raddr(raddr), .o_rdata(piv_q));
    tdss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_up (
        .i_clk(i_clk), .i_we(i_cmd.write_row), .i_waddr(i_row),
        .i_wdata(r_sup), .i_raddr(raddr), .o_rdata(up_q));
    tdss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs (
        .i_clk(i_clk), .i_we(i_cmd.write_row), .i_waddr(i_row),
        .i_wdata(i_first ? r_rr : n_rr), .i_raddr(raddr), .o_rdata(rhs_q));

    // divider operands: multiplier in elimination, x in back substitution
    assign div_start = i_cmd.div_start;
    assign div_a     = i_cmd.bs_num ? r_num : (i_bs_first ? r_num : r_num);
    assign div_b     = r_piv;

    tdss_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(div_a), .i_b(div_b), .o_busy(o_stat.div_busy), .o_q(div_q));

    // differences after products
    always_comb begin
        n_piv = sat32(64'(r_diag) - 64'(qscale(r_prod)));
        n_rr  = sat32(64'(r_rhs) - 64'(qscale(r_prod)));
        n_num = i_bs_first ? rhs_q : sat32(64'(rhs_q) - 64'(qscale(r_prod)));
    end

    always_ff @(posedge i_clk) begin
        // latch the row beat, stage dividend and divisor
        if (i_cmd.load_row) begin
            r_diag <= i_diag_value;
            r_sup  <= i_last_row ? '0 : i_super_value;
            r_rhs  <= i_rhs_value;
            r_num  <= i_sub_value;
            if (i_first) begin
                r_piv <= i_diag_value;
                r_rr  <= i_rhs_value;
            end
        end
        // previous pivot arrives from the registered store read
        if (i_cmd.div_start && !i_cmd.bs_num) begin
            r_piv <= piv_q;
        end
        // first product: m * upper[i-1]
        if (i_cmd.mul_a) begin
            r_m    <= div_q;
            r_prod <= 64'(div_q) * 64'(up_q);
        end
        // pivot and second product: m * rhs'[i-1]
        if (i_cmd.mul_b) begin
            r_piv  <= n_piv;
            r_prod <= 64'(r_m) * 64'(rhs_q);
        end
        if (i_cmd.write_row && !i_first) begin
            r_rr <= n_rr;
        end
        // back substitution: upper * x[i+1]
        if (i_cmd.bs_read) begin
            r_prod <= 64'(up_q) * 64'(r_x);
        end
        if (i_cmd.bs_num) begin
            r_num <= n_num;
            r_piv <= piv_q;
        end
        if (i_cmd.bs_done) begin
            r_x <= div_q;
        end
    end

    assign o_piv_zero  = (r_piv == '0);
    assign o_diag_zero = (r_diag == '0);
    assign o_x_value   = r_x;
endmodule

### hw/rtl/tdss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_ctrl
// sequencer for elimination, back substitution and the output handshake
// ----------------------------------------------------------------------------
module tdss_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_last_row,
    output logic                        o_valid,
    input  logic                        i_ready,
    output tdss_pkg::t_cmd              o_cmd,
    input  tdss_pkg::t_stat             i_stat,
    output logic [tdss_pkg::ADDR_W-1:0] o_row,
    output logic                        o_first,
    output logic                        o_bs_first,
    input  logic                        i_piv_zero,
    input  logic                        i_diag_zero,
    output logic [5:0]                  o_row_index,
    output logic                        o_last_result,
    output logic                        o_singular,
    output logic                        o_overflowed
);
    import tdss_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_MULA  = 4'd4;
    localparam logic [3:0] S_MULB  = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_BRD   = 4'd7;
    localparam logic [3:0] S_BPROD = 4'd8;
    localparam logic [3:0] S_BNUM  = 4'd9;
    localparam logic [3:0] S_BDIV  = 4'd10;
    localparam logic [3:0] S_BWAIT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_row;
    logic              r_last, r_sing, r_ovf, r_bs_first, r_valid;
    logic              accept, out_take, full;

    assign full     = (r_count == CNT_W'(MAX_ROWS));
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_take = r_valid && i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_row = !full;
                    if (full) n_state = i_last_row ? S_BRD : S_IDLE;
                    else if (r_count == '0) n_state = S_WR;
                    else n_state = S_RD;
                end
            end
            S_RD:    n_state = S_DIV;
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT:  if (!i_stat.div_busy) n_state = S_MULA;
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.write_row = 1'b1;
                n_state = r_last ? S_BRD : S_IDLE;
            end
            S_BRD: begin
                o_cmd.bs_read = 1'b1;
                n_state = S_BPROD;
            end
            // hold the current row address so the stores show row i next cycle
            S_BPROD: begin
                o_cmd.bs_read = 1'b1;
                n_state = S_BNUM;
            end
            S_BNUM: begin
                o_cmd.bs_num = 1'b1;
                n_state = S_BDIV;
            end
            S_BDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.bs_num    = 1'b0;
                n_state = S_BWAIT;
            end
            S_BWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.bs_done = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_take) begin
                    o_cmd.dec_row = 1'b1;
                    n_state = (r_row == '0) ? S_IDLE : S_BRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_row      <= '0;
            r_last     <= 1'b0;
            r_sing     <= 1'b0;
            r_ovf      <= 1'b0;
            r_bs_first <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_last <= i_last_row;
                if (full) begin
                    r_ovf <= 1'b1;
                    if (i_last_row) begin
                        r_row      <= ADDR_W'(MAX_ROWS - 1);
                        r_bs_first <= 1'b1;
                    end
                end else begin
                    r_row <= r_count[ADDR_W-1:0];
                end
            end
            if (o_cmd.write_row) begin
                if (i_diag_zero || i_piv_zero) r_sing <= 1'b1;
                r_count <= r_count + 1'b1;
                r_bs_first <= 1'b1;
            end
            if (o_cmd.bs_done) r_valid <= 1'b1;
            if (o_cmd.dec_row) begin
                r_valid    <= 1'b0;
                r_bs_first <= 1'b0;
                r_row      <= r_row - 1'b1;
                if (r_row == '0) begin
                    r_count <= '0;
                    r_sing  <= 1'b0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    assign o_row         = r_row;
    assign o_first       = (r_count == '0);
    assign o_bs_first    = r_bs_first;
    assign o_valid       = r_valid;
    assign o_row_index   = 6'(r_row);
    assign o_last_result = (r_row == '0);
    assign o_singular    = r_sing;
    assign o_overflowed  = r_ovf;
endmodule

### bench/tdss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_checker
// watches both channels of the tridiagonal solver, predicts each solution
// beat with its own thomas algorithm model and compares field by field
// ----------------------------------------------------------------------------
module tdss_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_sub_value,
    input  logic signed [31:0] i_diag_value,
    input  logic signed [31:0] i_super_value,
    input  logic signed [31:0] i_rhs_value,
    input  logic               i_last_row,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_x_value,
    input  logic [5:0]         i_row_index,
    input  logic               i_last_result,
    input  logic               i_singular,
    input  logic               i_overflowed,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_solutions_seen,
    output int                 o_singular_seen,
    output int                 o_overflow_seen
);
    import tdss_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic [5:0]         row;
        logic               last;
        logic               sing;
        logic               ovf;
    } t_solution;

    t_solution          solution_q[$];
    logic signed [31:0] pivot_mem[MAX_ROWS];
    logic signed [31:0] upper_mem[MAX_ROWS];
    logic signed [31:0] rhs_mem[MAX_ROWS];
    int                 rows_held;
    logic               sing_flag;
    logic               ovf_flag;

    assign o_pending = solution_q.size();

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor-rounded fixed point product
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    // truncating fixed point quotient, saturates on a zero divisor
    function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] num;
        if (b == 0) begin
            if (a > 0) return 64'sd2147483647;
            if (a < 0) return -64'sd2147483648;
            return 0;
        end
        num = a <<< FRAC_BITS;
        return clamp32(num / b);
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // forward elimination of one row beat, back substitution on the last one
    task automatic eliminate_row();
        logic signed [63:0] m;
        logic signed [63:0] piv;
        logic signed [63:0] rr;
        logic signed [63:0] num;
        logic signed [63:0] xs[MAX_ROWS];
        t_solution          s;
        if (rows_held < MAX_ROWS) begin
            if (i_diag_value == 0) sing_flag = 1'b1;
            if (rows_held == 0) begin
                piv = i_diag_value;
                rr  = i_rhs_value;
            end else begin
                m   = fx_div(i_sub_value, pivot_mem[rows_held-1]);
                piv = clamp32(i_diag_value - fx_mul(m, upper_mem[rows_held-1]));
                rr  = clamp32(i_rhs_value - fx_mul(m, rhs_mem[rows_held-1]));
            end
            if (piv == 0) sing_flag = 1'b1;
            pivot_mem[rows_held] = piv[31:0];
            upper_mem[rows_held] = i_last_row ? 32'sd0 : i_super_value;
            rhs_mem[rows_held]   = rr[31:0];
            rows_held++;
        end else begin
            ovf_flag = 1'b1;
        end
        if (!i_last_row) return;
        for (int i = rows_held - 1; i >= 0; i--) begin
            num = rhs_mem[i];
            if (i + 1 < rows_held) num = clamp32(num - fx_mul(upper_mem[i], xs[i+1]));
            xs[i] = fx_div(num, pivot_mem[i]);
        end
        for (int i = rows_held - 1; i >= 0; i--) begin
            s.x    = xs[i][31:0];
            s.row  = 6'(i);
            s.last = (i == 0);
            s.sing = sing_flag;
            s.ovf  = ovf_flag;
            solution_q.push_back(s);
        end
        if (sing_flag) o_singular_seen++;
        if (ovf_flag) o_overflow_seen++;
        rows_held = 0;
        sing_flag = 1'b0;
        ovf_flag  = 1'b0;
    endtask

    // compare one solution beat with the oldest prediction
    task automatic check_solution();
        t_solution s;
        o_solutions_seen++;
        if (solution_q.size() == 0) begin
            report("unexpected beat", {32'd0, i_x_value}, 64'd0);
            return;
        end
        s = solution_q.pop_front();
        if (i_x_value !== s.x) report("x_value", {32'd0, i_x_value}, {32'd0, s.x});
        if (i_row_index !== s.row) report("row_index", 64'(i_row_index), 64'(s.row));
        if (i_last_result !== s.last) report("last_result", 64'(i_last_result), 64'(s.last));
        if (i_singular !== s.sing) report("singular", 64'(i_singular), 64'(s.sing));
        if (i_overflowed !== s.ovf) report("overflowed", 64'(i_overflowed), 64'(s.ovf));
    endtask

    initial begin
        o_fail_count     = 0;
        o_solutions_seen = 0;
        o_singular_seen  = 0;
        o_overflow_seen  = 0;
        rows_held        = 0;
        sing_flag        = 1'b0;
        ovf_flag         = 1'b0;
    end

    // input beats first so a same-edge output sees its prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) eliminate_row();
            if (i_out_valid && i_out_ready) check_solution();
        end
    end
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives row beats into the tridiagonal solver with random gaps and output
// stalls; directed corner runs first, then random systems of mixed sizes
// ----------------------------------------------------------------------------
module tb_top;
    import tdss_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ROWS    = 50;
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_sub_value;
    logic signed [31:0] i_diag_value;
    logic signed [31:0] i_super_value;
    logic signed [31:0] i_rhs_value;
    logic               i_last_row;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_x_value;
    logic [5:0]         o_row_index;
    logic               o_last_result;
    logic               o_singular;
    logic               o_overflowed;

    int   fail_count;
    int   pending;
    int   solutions_seen;
    int   singular_runs;
    int   overflow_runs;
    int   rows_sent;
    int   runs_sent;
    int   idle_cycles;
    logic hold_request;

    tridiagonal_system_solver_top u_dut (.*);

    tdss_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_sub_value      (i_sub_value),
        .i_diag_value     (i_diag_value),
        .i_super_value    (i_super_value),
        .i_rhs_value      (i_rhs_value),
        .i_last_row       (i_last_row),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_x_value        (o_x_value),
        .i_row_index      (o_row_index),
        .i_last_result    (o_last_result),
        .i_singular       (o_singular),
        .i_overflowed     (o_overflowed),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_solutions_seen (solutions_seen),
        .o_singular_seen  (singular_runs),
        .o_overflow_seen  (overflow_runs)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(5, 1);
        return $urandom_range(150, 20);
    endfunction

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("[tridiagonal_system_solver_top] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold on request
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
                i_ready = 1'b1;
            end else if (gap_len() > 0 && $urandom_range(3) == 0) begin
                i_ready = 1'b0;
                repeat (gap_len()) @(negedge i_clk);
                i_ready = 1'b1;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // one row beat, called and returning at a falling edge
    task automatic send_row(input logic signed [31:0] sub, input logic signed [31:0] diag,
                            input logic signed [31:0] sup, input logic signed [31:0] rhs,
                            input logic last, input logic gaps);
        int g;
        i_valid       = 1'b1;
        i_sub_value   = sub;
        i_diag_value  = diag;
        i_super_value = sup;
        i_rhs_value   = rhs;
        i_last_row    = last;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        rows_sent++;
        if (last) runs_sent++;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // mostly moderate values, sometimes full range
    function automatic logic signed [31:0] rand_value();
        if ($urandom_range(9) < 2) return $urandom;
        return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic logic signed [31:0] rand_diag();
        logic signed [31:0] d;
        if ($urandom_range(19) == 0) return $urandom;
        if ($urandom_range(39) == 0) return 32'sd0;
        d = $signed($urandom_range(32'h0010_0000, 32'h0004_0000));
        return $urandom_range(1) ? d : -d;
    endfunction

    task automatic send_system(input int n, input logic gaps);
        for (int i = 0; i < n; i++)
            send_row(rand_value(), rand_diag(), rand_value(), rand_value(), i == n - 1, gaps);
    endtask

    initial begin
        int n;
        int pick;
        int random_rows;
        i_valid       = 1'b0;
        i_sub_value   = '0;
        i_diag_value  = '0;
        i_super_value = '0;
        i_rhs_value   = '0;
        i_last_row    = 1'b0;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        rows_sent     = 0;
        runs_sent     = 0;
        i_rst_n       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single-row systems, including divide by zero with each dividend sign
        send_row(S_MAX, Q_ONE, S_MIN, S_MAX, 1'b1, 1'b1);
        send_row(32'sd0, 32'sd0, 32'sd0, 32'sd5, 1'b1, 1'b1);
        send_row(32'sd0, 32'sd0, 32'sd0, -32'sd5, 1'b1, 1'b1);
        send_row(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1);
        send_row(32'sd0, S_MIN, S_MAX, S_MIN, 1'b1, 1'b0);
        // extremes everywhere, saturating products and quotients
        send_row(S_MIN, S_MIN, S_MAX, S_MIN, 1'b0, 1'b1);
        send_row(S_MAX, S_MAX, S_MIN, S_MAX, 1'b1, 1'b1);
        send_row(32'sd1, -32'sd1, -32'sd1, 32'sd1, 1'b0, 1'b0);
        send_row(S_MIN, 32'sd1, 32'sd0, S_MAX, 1'b1, 1'b1);
        // zero pivot in the middle of a run
        send_row(32'sd0, Q_ONE, Q_ONE, Q_ONE, 1'b0, 1'b1);
        send_row(Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, 1'b0, 1'b1);
        send_row(Q_ONE, 4 * Q_ONE, 32'sd0, -Q_ONE, 1'b1, 1'b1);
        // ordinary well-conditioned system
        send_row(32'sd0, 4 * Q_ONE, Q_ONE, Q_ONE, 1'b0, 1'b0);
        send_row(Q_ONE, 4 * Q_ONE, Q_ONE, 2 * Q_ONE, 1'b0, 1'b0);
        send_row(Q_ONE, 4 * Q_ONE, Q_ONE, 3 * Q_ONE, 1'b1, 1'b0);

        // sender pauses until every solution has come out
        i_valid = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);

        // a full-depth system, then one two rows past the depth with the mark on the second
        send_system(MAX_ROWS, 1'b0);
        for (int i = 0; i < MAX_ROWS + 2; i++)
            send_row(rand_value(), rand_diag(), rand_value(), rand_value(),
                     i == MAX_ROWS + 1, 1'b0);

        // long output hold over a pending solution while further rows are held off
        send_system(20, 1'b0);
        hold_request = 1'b1;
        send_system(3, 1'b0);
        send_system(3, 1'b0);

        // random systems, mostly small
        random_rows = 0;
        while (random_rows < RANDOM_ROWS) begin
            pick = $urandom_range(99);
            if (pick < 85) n = $urandom_range(6, 1);
            else if (pick < 97) n = $urandom_range(20, 7);
            else n = $urandom_range(MAX_ROWS, 40);
            send_system(n, $urandom_range(3) != 0);
            random_rows += n;
        end
        i_valid = 1'b0;

        wait (pending == 0);
        repeat (200) @(negedge i_clk);
        $display("sent %0d rows in %0d systems, checked %0d solution beats",
                 rows_sent, runs_sent, solutions_seen);
        $display("%0d systems flagged singular, %0d flagged overflow",
                 singular_runs, overflow_runs);
        if (fail_count == 0) begin
            $display("[tridiagonal_system_solver_top] OK");
        end else begin
            $display("[tridiagonal_system_solver_top] ERROR");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tdss_pkg.sv
hw/rtl/tdss_ram.sv
hw/rtl/tdss_div.sv
hw/rtl/tdss_datapath.sv
hw/rtl/tdss_ctrl.sv
hw/rtl/tridiagonal_system_solver_top.sv
bench/tdss_checker.sv
bench/tb_top.sv
